>>> rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: melody tone sequencer shared definitions
// Widths, register codes, command codes and the note table entry layout.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int NOTE_W      = 6;                // note index width
    localparam int NOTE_LIMIT  = 2 ** NOTE_W;      // index wraps here at the latest
    localparam int COUNT_W     = 7;                // song length register width
    localparam int TIME_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0]  MS_PERIOD_RST  = 16'd2000;
    localparam logic [COUNT_W-1:0] SONG_LEN_RST   = 7'd47;
    localparam logic [TIME_W-1:0]  TIME_MAX       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MS_PERIOD  = 1'b0,
        REG_SONG_LEN   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] reload;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
    } note_entry_t;

    localparam int ENTRY_W = $bits(note_entry_t);

endpackage

>>> rtl/mts_if.sv
// ----------------------------------------------------------------------------
// mts_if: melody tone sequencer channel interfaces
// Request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface mts_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        button_held;
    logic [5:0]  entry_index;
    logic [15:0] entry_reload;
    logic [15:0] entry_start;
    logic [15:0] entry_end;

    modport source (output valid, command, button_held, entry_index, entry_reload,
                    entry_start, entry_end, input ready);
    modport sink   (input valid, command, button_held, entry_index, entry_reload,
                    entry_start, entry_end, output ready);
endinterface

interface mts_result_if;
    logic       valid;
    logic       ready;
    logic       piezo_level;
    logic       leds_on;
    logic [5:0] current_note;
    logic       tone_active;

    modport source (output valid, piezo_level, leds_on, current_note, tone_active,
                    input ready);
    modport sink   (input valid, piezo_level, leds_on, current_note, tone_active,
                    output ready);
endinterface

interface mts_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old data on
// a same-address collision.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/melody_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer_top: buzzer melody player
// Plays a note table on a piezo: one tone-clock tick or one table write per
// request, one result per request.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  item    | in  | valid / ready | command, button_held, entry_index,
//          |     |               | entry_reload, entry_start, entry_end
//  result  | out | valid / ready | piezo_level, leds_on, current_note, tone_active
//  cfg     | in  | valid / ready | index (0 ms_period, 1 song_len), data
//
//  One request per cycle unless a waiting result stalls: a request accepted
//  at an edge has its result in the output register from that edge on.
//  The note table RAM is read every cycle at the index the state will hold
//  after this edge, so the entry for the next tick is always ready; a write
//  to that same entry in the same cycle is forwarded around the RAM.
//  Reset (rst_n low, async) restores config, state and result valid; payload
//  registers and the table hold garbage until written. cfg is always ready.
//  item.ready drops only while a result waits and result.ready is low.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_top
    import mts_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    mts_item_if.sink     item,
    mts_result_if.source result,
    mts_cfg_if.sink      cfg
);

    // configuration registers
    logic [TIME_W-1:0]  ms_period_reg;
    logic [COUNT_W-1:0] song_len_reg;

    // player state
    logic [TIME_W-1:0]  ms_prescale_reg,  ms_prescale_next;
    logic [TIME_W-1:0]  song_time_reg,    song_time_next;
    logic [NOTE_W-1:0]  note_index_reg,   note_index_next;
    logic [TIME_W-1:0]  tone_counter_reg, tone_counter_next;
    logic [TIME_W-1:0]  tone_reload_reg,  tone_reload_next;
    logic               tone_enabled_reg, tone_enabled_next;
    logic               piezo_state_reg,  piezo_state_next;

    // result register
    logic               res_valid_reg;
    logic               res_piezo_reg;
    logic               res_tone_reg;
    logic [NOTE_W-1:0]  res_note_reg;

    // table access
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;
    note_entry_t        tbl_wentry;
    logic               fwd_hit_reg, fwd_hit_next;
    note_entry_t        fwd_entry_reg;
    note_entry_t        cur_entry;

    logic               item_accept;
    logic               is_write;
    logic               tick;
    logic [TIME_W:0]    prescale_inc;
    logic [COUNT_W-1:0] index_inc;
    logic               index_wrap;

    // ---------------------------------------------------------------- handshake
    assign item.ready  = !res_valid_reg || result.ready;
    assign item_accept = item.valid && item.ready;
    assign is_write    = (item.command == CMD_WRITE);
    assign tick        = item_accept && !is_write;
    assign cfg.ready   = 1'b1;

    // ---------------------------------------------------------------- note table
    assign tbl_wentry.reload = item.entry_reload;
    assign tbl_wentry.start  = item.entry_start;
    assign tbl_wentry.stop   = item.entry_end;
    assign tbl_waddr         = TBL_AW'(item.entry_index);
    // entries beyond the table are dropped
    assign tbl_we = item_accept && is_write && (32'(item.entry_index) < TABLE_DEPTH);
    // read where the index will be after this edge
    assign tbl_raddr    = TBL_AW'(note_index_next);
    assign fwd_hit_next = tbl_we && (tbl_waddr == tbl_raddr);
    assign cur_entry    = fwd_hit_reg ? fwd_entry_reg : note_entry_t'(tbl_rdata);

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_note_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (ENTRY_W'(tbl_wentry)),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // ---------------------------------------------------------------- tick logic
    assign prescale_inc = {1'b0, ms_prescale_reg} + 1'b1;
    assign index_inc    = {1'b0, note_index_reg} + 1'b1;
    assign index_wrap   = (index_inc >= song_len_reg)
                       || (32'(index_inc) >= TABLE_DEPTH)
                       || (32'(index_inc) >= NOTE_LIMIT);

    always_comb
    begin
        ms_prescale_next  = ms_prescale_reg;
        song_time_next    = song_time_reg;
        note_index_next   = note_index_reg;
        tone_counter_next = tone_counter_reg;
        tone_reload_next  = tone_reload_reg;
        tone_enabled_next = tone_enabled_reg;
        piezo_state_next  = piezo_state_reg;

        if (tick)
        begin
            // free-running tone counter, uses the enable from before the tick
            if (tone_counter_reg == TIME_MAX)
            begin
                tone_counter_next = tone_reload_reg;
                if (tone_enabled_reg)
                begin
                    piezo_state_next = !piezo_state_reg;
                end
            end
            else
            begin
                tone_counter_next = tone_counter_reg + 1'b1;
            end

            if (!item.button_held)
            begin
                tone_enabled_next = 1'b0;
                note_index_next   = '0;
                song_time_next    = '0;
                ms_prescale_next  = '0;
            end
            else
            begin
                // zero period acts as one: the compare always passes
                if (prescale_inc >= {1'b0, ms_period_reg})
                begin
                    ms_prescale_next = '0;
                    if (song_time_reg != TIME_MAX)
                    begin
                        song_time_next = song_time_reg + 1'b1;
                    end
                end
                else
                begin
                    ms_prescale_next = prescale_inc[TIME_W-1:0];
                end

                // judge the current note against the new song time;
                // exactly at start or end the state holds
                if (song_time_next < cur_entry.start)
                begin
                    tone_enabled_next = 1'b0;
                end
                else if ((song_time_next > cur_entry.start)
                      && (song_time_next < cur_entry.stop))
                begin
                    if (!tone_enabled_reg)
                    begin
                        tone_reload_next  = cur_entry.reload;
                        tone_enabled_next = 1'b1;
                    end
                end
                else if (song_time_next > cur_entry.stop)
                begin
                    tone_enabled_next = 1'b0;
                    note_index_next   = index_wrap ? '0 : index_inc[NOTE_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_period_reg    <= MS_PERIOD_RST;
            song_len_reg     <= SONG_LEN_RST;
            ms_prescale_reg  <= '0;
            song_time_reg    <= '0;
            note_index_reg   <= '0;
            tone_counter_reg <= '0;
            tone_reload_reg  <= '0;
            tone_enabled_reg <= 1'b0;
            piezo_state_reg  <= 1'b1;
            res_valid_reg    <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_MS_PERIOD: ms_period_reg <= cfg.data;
                    REG_SONG_LEN:  song_len_reg  <= cfg.data[COUNT_W-1:0];
                    default:       ;
                endcase
            end

            ms_prescale_reg  <= ms_prescale_next;
            song_time_reg    <= song_time_next;
            note_index_reg   <= note_index_next;
            tone_counter_reg <= tone_counter_next;
            tone_reload_reg  <= tone_reload_next;
            tone_enabled_reg <= tone_enabled_next;
            piezo_state_reg  <= piezo_state_next;
            fwd_hit_reg      <= fwd_hit_next;

            if (item_accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            res_piezo_reg <= piezo_state_next;
            res_tone_reg  <= tone_enabled_next;
            res_note_reg  <= note_index_next;
        end
        if (fwd_hit_next)
        begin
            fwd_entry_reg <= tbl_wentry;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.piezo_level  = res_piezo_reg;
    assign result.leds_on      = res_tone_reg;
    assign result.current_note = res_note_reg;
    assign result.tone_active  = res_tone_reg;

endmodule

>>> rtl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the melody tone sequencer
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module mts_checker
    import mts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_command,
    input logic              item_button_held,
    input logic              res_valid,
    input logic              res_ready,
    input logic              res_piezo_level,
    input logic              res_leds_on,
    input logic [NOTE_W-1:0] res_current_note,
    input logic              res_tone_active
);

    logic item_fire;
    assign item_fire = item_valid && item_ready;

    // held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_piezo_level)
            && $stable(res_current_note) && $stable(res_tone_active))
        else $error("result changed while stalled");

    // every accepted request shows a result on the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> res_valid)
        else $error("accepted request produced no result");

    // LEDs follow the tone enable
    a_leds_tone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_leds_on == res_tone_active)
        else $error("leds_on differs from tone_active");

    // releasing the button silences and rewinds the player
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && (item_command == CMD_TICK) && !item_button_held
            |=> !res_tone_active && (res_current_note == '0))
        else $error("release did not clear tone and note index");

endmodule

bind melody_tone_sequencer_top mts_checker u_mts_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_command     (item.command),
    .item_button_held (item.button_held),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_piezo_level  (result.piezo_level),
    .res_leds_on      (result.leds_on),
    .res_current_note (result.current_note),
    .res_tone_active  (result.tone_active)
);
